// ===== hw/rtl/synth_voice_waveform_mixer_defines.svh =====
// ----------------------------------------------------------------------------
// Voice waveform mixer assertion macros
// Same-cycle and next-cycle implication checks, empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef SYNTH_VOICE_WAVEFORM_MIXER_DEFINES_SVH
`define SYNTH_VOICE_WAVEFORM_MIXER_DEFINES_SVH
`ifndef SYNTH
`define SWM_ASSERT_NOW(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("swm: same-cycle check failed");
`define SWM_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("swm: next-cycle check failed");
`else
`define SWM_ASSERT_NOW(lbl, clk, rst_n, pre, post)
`define SWM_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif
`endif

// ===== hw/rtl/swm_pkg.sv =====
// ----------------------------------------------------------------------------
// swm_pkg
// Shared types and constants of the voice waveform mixer.
// ----------------------------------------------------------------------------
package swm_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_WAVE_SELECT   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PULSE_WIDTH   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MASTER_VOLUME = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SUB_MODE      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SUB_LEVEL     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_UNISON_VOICES = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_UNISON_WET    = 3'd6;

    localparam logic [2:0] WAVE_SAW      = 3'd0;
    localparam logic [2:0] WAVE_SQUARE   = 3'd1;
    localparam logic [2:0] WAVE_TRIANGLE = 3'd2;
    localparam logic [2:0] WAVE_SINE     = 3'd3;
    localparam logic [2:0] WAVE_PULSE    = 3'd4;

    localparam logic [1:0] SUB_OFF      = 2'd0;
    localparam logic [1:0] SUB_SQ_OCT1  = 2'd1;
    localparam logic [1:0] SUB_SQ_OCT2  = 2'd2;
    localparam logic [1:0] SUB_SINE     = 2'd3;

    localparam logic signed [16:0] ONE_Q15     = 17'sd32768;
    localparam logic signed [16:0] NEG_ONE_Q15 = -17'sd32768;
    localparam logic [15:0]        UNITY_GAIN  = 16'd32768;
    localparam logic [15:0]        PW_MIN      = 16'd655;
    localparam logic [15:0]        PW_MAX      = 16'd64880;
    localparam logic [15:0]        SEVEN_TENTHS_Q16 = 16'd45875;
    localparam logic signed [15:0] SAMPLE_MAX  = 16'sh7FFF;

    typedef struct packed {
        logic [2:0]  wave_sel;
        logic [15:0] pulse_width;
        logic [1:0]  sub_mode;
        logic [14:0] sub_gain;
        logic        uni_on;
        logic [15:0] dry_gain;
        logic [15:0] wet_gain;
        logic [15:0] master_gain;
    } t_cfg_bus;

endpackage

// ===== hw/rtl/swm_cfg.sv =====
// ----------------------------------------------------------------------------
// swm_cfg
// Configuration registers and the gains derived from them.
// ----------------------------------------------------------------------------
module swm_cfg #(
    parameter int MAX_UNISON = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [swm_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [swm_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output swm_pkg::t_cfg_bus                 o_cfg
);
    import swm_pkg::*;

    localparam int RC_N = MAX_UNISON;
    localparam int DW   = (RC_N > 1) ? $clog2(RC_N) : 1;

    typedef logic [32:0] t_rc [RC_N];

    // ceil(2^32 / d): exact quotient for numerators below 2^16
    function automatic t_rc build_rc();
        t_rc rc;
        rc[0] = '0;
        for (int d = 1; d < RC_N; d++) begin
            rc[d] = 33'(((64'd1 << 32) + 64'(d) - 64'd1) / 64'(d));
        end
        return rc;
    endfunction

    localparam t_rc RECIP = build_rc();

    logic [2:0]  r_wave_select;
    logic [15:0] r_pulse_width;
    logic [15:0] r_master_volume;
    logic [1:0]  r_sub_mode;
    logic [15:0] r_sub_level;
    logic [3:0]  r_unison_voices;
    logic [15:0] r_unison_wet;

    logic [14:0] r_sub_gain;
    logic        r_uni_on;
    logic [15:0] r_dry_gain;
    logic [15:0] r_div_num;
    logic [32:0] r_div_mul;
    logic [15:0] r_wet_gain;
    logic [15:0] r_master_gain;

    logic [15:0] n_pw;
    logic [15:0] n_sl;
    logic [15:0] n_mv;
    logic [15:0] n_wet;
    logic [4:0]  n_voices;
    logic [3:0]  n_div;
    logic [31:0] n_sub_prod;
    logic [48:0] n_div_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave_select   <= WAVE_SINE;
            r_pulse_width   <= 16'd32768;
            r_master_volume <= 16'd32768;
            r_sub_mode      <= SUB_OFF;
            r_sub_level     <= '0;
            r_unison_voices <= 4'd1;
            r_unison_wet    <= 16'd32768;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_WAVE_SELECT:   r_wave_select   <= i_cfg_data[2:0];
                REG_PULSE_WIDTH:   r_pulse_width   <= i_cfg_data;
                REG_MASTER_VOLUME: r_master_volume <= i_cfg_data;
                REG_SUB_MODE:      r_sub_mode      <= i_cfg_data[1:0];
                REG_SUB_LEVEL:     r_sub_level     <= i_cfg_data;
                REG_UNISON_VOICES: r_unison_voices <= i_cfg_data[3:0];
                REG_UNISON_WET:    r_unison_wet    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_pw = r_pulse_width;
        if (n_pw < PW_MIN) n_pw = PW_MIN;
        if (n_pw > PW_MAX) n_pw = PW_MAX;
        n_sl  = (r_sub_level > UNITY_GAIN) ? UNITY_GAIN : r_sub_level;
        n_mv  = (r_master_volume > UNITY_GAIN) ? UNITY_GAIN : r_master_volume;
        n_wet = (r_unison_wet > UNITY_GAIN) ? UNITY_GAIN : r_unison_wet;
        n_voices = {1'b0, r_unison_voices};
        if (n_voices == 5'd0) n_voices = 5'd1;
        if (n_voices > 5'(MAX_UNISON)) n_voices = 5'(MAX_UNISON);
        n_div      = 4'(n_voices - 5'd1);
        n_sub_prod = 32'(n_sl) * 32'(SEVEN_TENTHS_Q16) + 32'd32768;
        n_div_prod = 49'(r_div_num) * 49'(r_div_mul);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub_gain    <= '0;
            r_uni_on      <= 1'b0;
            r_dry_gain    <= '0;
            r_div_num     <= '0;
            r_div_mul     <= '0;
            r_wet_gain    <= '0;
            r_master_gain <= UNITY_GAIN;
        end else begin
            r_sub_gain    <= n_sub_prod[30:16];
            r_uni_on      <= (n_voices > 5'd1) && (n_wet < UNITY_GAIN);
            r_dry_gain    <= UNITY_GAIN - n_wet;
            r_div_num     <= n_wet + 16'(n_div >> 1);
            r_div_mul     <= RECIP[n_div[DW-1:0]];
            r_wet_gain    <= n_div_prod[47:32];
            r_master_gain <= n_mv;
        end
    end

    always_comb begin
        o_cfg.wave_sel    = r_wave_select;
        o_cfg.pulse_width = n_pw;
        o_cfg.sub_mode    = r_sub_mode;
        o_cfg.sub_gain    = r_sub_gain;
        o_cfg.uni_on      = r_uni_on;
        o_cfg.dry_gain    = r_dry_gain;
        o_cfg.wet_gain    = r_wet_gain;
        o_cfg.master_gain = r_master_gain;
    end

endmodule

// ===== hw/rtl/swm_sine_rom.sv =====
// ----------------------------------------------------------------------------
// swm_sine_rom
// Two-port sine table with registered read data.
// ----------------------------------------------------------------------------
module swm_sine_rom #(
    parameter int DEPTH = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [$clog2(DEPTH)-1:0]   i_addr_a,
    input  logic [$clog2(DEPTH)-1:0]   i_addr_b,
    output logic signed [16:0]         o_data_a,
    output logic signed [16:0]         o_data_b
);
    import swm_pkg::*;

    localparam longint unsigned TWO_PI_Q30 = 64'd6746518853;

    typedef logic signed [16:0] t_rom [DEPTH];
    typedef longint unsigned t_den [6];

    localparam t_den TAYLOR_DEN = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};

    // Q30 Taylor series over the first quadrant, mirrored per quadrant
    function automatic t_rom build_rom();
        t_rom            rom;
        longint unsigned u;
        longint unsigned r;
        longint unsigned t;
        longint unsigned a;
        longint unsigned a2;
        longint unsigned term;
        longint          sum;
        longint          v;
        int unsigned     q;
        for (int i = 0; i < DEPTH; i++) begin
            u    = (64'(i) << 32) / DEPTH;
            q    = 32'((u >> 30) & 64'd3);
            r    = u & 64'h3FFF_FFFF;
            t    = q[0] ? (64'h4000_0000 - r) : r;
            a    = (t * TWO_PI_Q30) >> 32;
            a2   = (a * a) >> 30;
            term = a;
            sum  = longint'(a);
            for (int k = 0; k < 6; k++) begin
                term = ((term * a2) >> 30) / TAYLOR_DEN[k];
                if (k[0] == 1'b0) sum = sum - longint'(term);
                else              sum = sum + longint'(term);
            end
            if (sum < 0) sum = 0;
            v = (sum + 16384) >>> 15;
            rom[i] = 17'((q >= 2) ? -v : v);
        end
        return rom;
    endfunction

    localparam t_rom SINE_ROM = build_rom();

    logic signed [16:0] r_data_a;
    logic signed [16:0] r_data_b;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data_a <= SINE_ROM[i_addr_a];
            r_data_b <= SINE_ROM[i_addr_b];
        end
    end

    assign o_data_a = r_data_a;
    assign o_data_b = r_data_b;

endmodule

// ===== hw/rtl/swm_datapath.sv =====
// ----------------------------------------------------------------------------
// swm_datapath
// Four-stage sample pipeline: wave shaping, sub blend, unison gain, master.
// ----------------------------------------------------------------------------
`include "synth_voice_waveform_mixer_defines.svh"

module swm_datapath #(
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  swm_pkg::t_cfg_bus  i_cfg,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [17:0]        i_phase_in,
    input  logic [2:0]         i_voice_num,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_sample_out
);
    import swm_pkg::*;

    localparam int IW = $clog2(SINE_TABLE_DEPTH);

    logic w_en1, w_en2, w_en3, w_en4;

    // stage 0: wave shaping and table addresses
    logic [15:0]        n_f;
    logic signed [16:0] n_half;
    logic [16:0]        n_mag;
    logic signed [17:0] n_tri;
    logic signed [16:0] n_wave;
    logic               n_is_sine;
    logic               n_sub_on;
    logic               n_sub_sine;
    logic signed [16:0] n_sub_sq;
    logic [15+IW:0]     n_idx_main;
    logic [15+IW:0]     n_idx_sub;

    always_comb begin
        n_f    = i_phase_in[15:0];
        n_half = {~n_f[15], ~n_f[15], n_f[14:0]};
        n_mag  = n_half[16] ? 17'(-n_half) : 17'(n_half);
        n_tri  = signed'({n_mag, 1'b0}) - 18'sd32768;
        n_is_sine = 1'b0;
        case (i_cfg.wave_sel)
            WAVE_SAW:      n_wave = n_half;
            WAVE_SQUARE:   n_wave = n_f[15] ? NEG_ONE_Q15 : ONE_Q15;
            WAVE_TRIANGLE: n_wave = n_tri[16:0];
            WAVE_PULSE:    n_wave = (n_f < i_cfg.pulse_width) ? ONE_Q15 : NEG_ONE_Q15;
            default: begin
                n_wave    = ONE_Q15;
                n_is_sine = 1'b1;
            end
        endcase
        n_sub_on   = (i_cfg.sub_mode != SUB_OFF) && (i_voice_num == 3'd0);
        n_sub_sine = (i_cfg.sub_mode == SUB_SINE);
        if (i_cfg.sub_mode == SUB_SQ_OCT1) n_sub_sq = i_phase_in[16] ? NEG_ONE_Q15 : ONE_Q15;
        else                               n_sub_sq = i_phase_in[17] ? NEG_ONE_Q15 : ONE_Q15;
        n_idx_main = (16 + IW)'(n_f) * (16 + IW)'(SINE_TABLE_DEPTH);
        n_idx_sub  = (16 + IW)'(i_phase_in[16:1]) * (16 + IW)'(SINE_TABLE_DEPTH);
    end

    logic               r_s1_valid;
    logic               r_s1_v0;
    logic signed [16:0] r_s1_wave;
    logic               r_s1_is_sine;
    logic               r_s1_sub_on;
    logic               r_s1_sub_sine;
    logic signed [16:0] r_s1_sub_sq;
    logic signed [16:0] w_sine_main;
    logic signed [16:0] w_sine_sub;

    swm_sine_rom #(
        .DEPTH (SINE_TABLE_DEPTH)
    ) u_sine_rom (
        .i_clk    (i_clk),
        .i_en     (w_en1),
        .i_addr_a (n_idx_main[15+IW:16]),
        .i_addr_b (n_idx_sub[15+IW:16]),
        .o_data_a (w_sine_main),
        .o_data_b (w_sine_sub)
    );

    // stage 1 -> 2: sub blend, s + (sub - s) * g
    logic signed [16:0] n_s;
    logic signed [16:0] n_sub;
    logic signed [17:0] n_diff;
    logic signed [33:0] n_blend;
    logic signed [16:0] n_s2_sample;

    always_comb begin
        n_s     = r_s1_is_sine ? w_sine_main : r_s1_wave;
        n_sub   = r_s1_sub_sine ? w_sine_sub : r_s1_sub_sq;
        n_diff  = 18'(n_sub) - 18'(n_s);
        n_blend = (34'(n_s) <<< 15) + n_diff * signed'({1'b0, i_cfg.sub_gain})
                  + 34'sd16384;
        n_s2_sample = r_s1_sub_on ? n_blend[31:15] : n_s;
    end

    logic               r_s2_valid;
    logic               r_s2_v0;
    logic signed [16:0] r_s2_sample;

    // stage 2 -> 3: unison gain
    logic [15:0]        n_uni_gain;
    logic signed [34:0] n_uni_prod;

    always_comb begin
        if (!i_cfg.uni_on)  n_uni_gain = UNITY_GAIN;
        else if (r_s2_v0)   n_uni_gain = i_cfg.dry_gain;
        else                n_uni_gain = i_cfg.wet_gain;
        n_uni_prod = r_s2_sample * signed'({1'b0, n_uni_gain}) + 35'sd16384;
    end

    logic               r_s3_valid;
    logic signed [16:0] r_s3_sample;

    // stage 3 -> 4: master volume and saturation
    logic signed [34:0] n_mst_prod;
    logic signed [16:0] n_mst;
    logic signed [15:0] n_sat;

    always_comb begin
        n_mst_prod = r_s3_sample * signed'({1'b0, i_cfg.master_gain}) + 35'sd16384;
        n_mst      = n_mst_prod[31:15];
        if (!n_mst[16] && n_mst[15]) n_sat = SAMPLE_MAX;
        else                         n_sat = n_mst[15:0];
    end

    logic               r_s4_valid;
    logic signed [15:0] r_s4_sample;

    assign w_en4 = !r_s4_valid || i_out_ready;
    assign w_en3 = !r_s3_valid || w_en4;
    assign w_en2 = !r_s2_valid || w_en3;
    assign w_en1 = !r_s1_valid || w_en2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else begin
            if (w_en1) r_s1_valid <= i_in_valid;
            if (w_en2) r_s2_valid <= r_s1_valid;
            if (w_en3) r_s3_valid <= r_s2_valid;
            if (w_en4) r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_s1_v0       <= (i_voice_num == 3'd0);
            r_s1_wave     <= n_wave;
            r_s1_is_sine  <= n_is_sine;
            r_s1_sub_on   <= n_sub_on;
            r_s1_sub_sine <= n_sub_sine;
            r_s1_sub_sq   <= n_sub_sq;
        end
        if (w_en2) begin
            r_s2_v0     <= r_s1_v0;
            r_s2_sample <= n_s2_sample;
        end
        if (w_en3) begin
            r_s3_sample <= n_uni_prod[31:15];
        end
        if (w_en4) begin
            r_s4_sample <= n_sat;
        end
    end

    assign o_in_ready   = w_en1;
    assign o_out_valid  = r_s4_valid;
    assign o_sample_out = r_s4_sample;

    `SWM_ASSERT_NOW(a_ready_when_out_empty, i_clk, i_rst_n, !r_s4_valid, o_in_ready)
    `SWM_ASSERT_NOW(a_blend_in_range, i_clk, i_rst_n, r_s2_valid, (r_s2_sample <= ONE_Q15) && (r_s2_sample >= NEG_ONE_Q15))
    `SWM_ASSERT_NEXT(a_s3_holds_on_stall, i_clk, i_rst_n, r_s3_valid && !w_en4, r_s3_valid && $stable(r_s3_sample))
    `SWM_ASSERT_NEXT(a_s1_holds_on_stall, i_clk, i_rst_n, r_s1_valid && !w_en2, r_s1_valid && $stable(r_s1_wave))

endmodule

// ===== hw/rtl/synth_voice_waveform_mixer.sv =====
// ----------------------------------------------------------------------------
// synth_voice_waveform_mixer
// Voice oscillator: saw/square/triangle/sine/pulse with sub-oscillator blend,
// unison dry/wet gain and master volume, saturated Q1.15 output.
// ----------------------------------------------------------------------------
//  channel  handshake                 payload
//  in       i_in_valid / o_in_ready   i_phase_in[17:0], i_voice_num[2:0]
//  out      o_out_valid / i_out_ready o_sample_out[15:0] signed
//  cfg      i_cfg_we                  i_cfg_index[2:0], i_cfg_data[15:0]
//
//  One request per cycle sustained while i_out_ready is high; each sample is
//  registered after the table read, blend multiplier, unison multiplier and
//  master multiplier. Derived gains are registered behind the written register.
//  Synchronous active-low reset clears the valid bits and the configuration
//  registers; sample data registers are not reset.
//  A stall holds each occupied stage; empty stages still fill behind it.
// ----------------------------------------------------------------------------
module synth_voice_waveform_mixer #(
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int MAX_UNISON       = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [swm_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [swm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [17:0]                      i_phase_in,
    input  logic [2:0]                       i_voice_num,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic signed [15:0]               o_sample_out
);
    import swm_pkg::*;

    t_cfg_bus w_cfg;

    swm_cfg #(
        .MAX_UNISON (MAX_UNISON)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    swm_datapath #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_phase_in   (i_phase_in),
        .i_voice_num  (i_voice_num),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_sample_out (o_sample_out)
    );

endmodule
